/* rtl/bba_pkg.sv */
// package: constants, codes and types for the block bitmap allocator
`default_nettype none

package bba_pkg;

    // map geometry
    localparam int MAP_BITS  = 4096;
    localparam int WORD_BITS = 64;
    localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W    = $clog2(MAP_WORDS);
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int IDX_W     = ADDR_W + BIT_W;
    localparam int LIM_W     = $clog2(MAP_BITS + 1);

    // field and register widths
    localparam int FDB_W      = 16;
    localparam int ZC_W       = 13;
    localparam int BLK_W      = 16;
    localparam int ALLOC_W    = 17;
    localparam int STATUS_W   = 2;
    localparam int FIDX_W     = BLK_W + 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_DATA_BLOCK = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ZONE_COUNT       = 1'd1;

    // request codes
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_SCAN    = 5'b00010,
        ST_FREE_RD = 5'b00100,
        ST_FREE_WR = 5'b01000,
        ST_FIN     = 5'b10000
    } state_t;

endpackage

`default_nettype wire

/* rtl/block_bitmap_allocator_core.sv */
// top level: first-fit block allocator over a free map held in one word-wide memory
// allocate: the scan reads the map words from word 0 in ST_SCAN, up to the last word below
//   the usable count, then ST_FIN registers the result; free reads in ST_FREE_RD, clears the
//   bit in ST_FREE_WR, then ST_FIN; a rejected request goes straight to ST_FIN; the scan reads one map word per cycle
// one item at a time: the next item is taken once the result is registered, and ST_FIN
//   waits while the output stalls
// reset: rst_n clears control state and all word valid bits, so the map reads as free
`default_nettype none

module block_bitmap_allocator_core (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   cfg_we,
    input  wire [bba_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire [bba_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  wire                                   in_valid,
    output logic                                  in_ready,
    input  wire                                   func,
    input  wire [bba_pkg::BLK_W-1:0]              block_number,
    output logic                                  out_valid,
    input  wire                                   out_ready,
    output logic [bba_pkg::ALLOC_W-1:0]           alloc_block,
    output logic [bba_pkg::STATUS_W-1:0]          status
);

    bba_pkg::state_t state_reg, state_next;

    logic [bba_pkg::FDB_W-1:0]     fdb_reg;
    logic [bba_pkg::ZC_W-1:0]      zc_reg;

    // map memory and per-word valid bits
    logic [bba_pkg::WORD_BITS-1:0] map_mem [bba_pkg::MAP_WORDS];
    logic [bba_pkg::MAP_WORDS-1:0] word_vld_reg;
    logic [bba_pkg::WORD_BITS-1:0] rdata_reg;
    logic                          rvld_reg;

    logic [bba_pkg::ADDR_W-1:0]    rd_word_reg, rd_word_next;
    logic [bba_pkg::ADDR_W-1:0]    chk_word_reg, chk_word_next;
    logic                          chk_vld_reg, chk_vld_next;
    logic [bba_pkg::BIT_W-1:0]     bit_sel_reg, bit_sel_next;

    logic [bba_pkg::ALLOC_W-1:0]   res_block_reg, res_block_next;
    logic [bba_pkg::STATUS_W-1:0]  res_status_reg, res_status_next;

    logic                          out_valid_reg;
    logic [bba_pkg::ALLOC_W-1:0]   alloc_block_reg;
    logic [bba_pkg::STATUS_W-1:0]  status_reg;

    logic                          mem_we;
    logic [bba_pkg::ADDR_W-1:0]    mem_waddr;
    logic [bba_pkg::WORD_BITS-1:0] mem_wdata;

    logic [bba_pkg::LIM_W-1:0]     limit;
    logic [bba_pkg::LIM_W-1:0]     limit_m1;
    logic [bba_pkg::ADDR_W-1:0]    last_word;
    logic [bba_pkg::LIM_W-1:0]     lim_words;
    logic [bba_pkg::BIT_W-1:0]     lim_rem;
    logic [bba_pkg::WORD_BITS-1:0] elig_mask;
    logic [bba_pkg::WORD_BITS-1:0] cur_word;
    logic [bba_pkg::WORD_BITS-1:0] cand;
    logic                          hit;
    logic [bba_pkg::BIT_W-1:0]     hit_pos;
    logic [bba_pkg::IDX_W-1:0]     hit_idx;
    logic [bba_pkg::FIDX_W-1:0]    fidx;
    logic                          free_oor;
    logic                          accept;
    logic                          out_free;

    function automatic logic [bba_pkg::BIT_W-1:0] lowest_set(
        input logic [bba_pkg::WORD_BITS-1:0] v
    );
        logic [bba_pkg::BIT_W-1:0] pos;
        pos = '0;
        for (int i = bba_pkg::WORD_BITS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                pos = bba_pkg::BIT_W'(i);
            end
        end
        return pos;
    endfunction

    assign in_ready    = (state_reg == bba_pkg::ST_IDLE);
    assign accept      = in_valid && in_ready;
    assign out_valid   = out_valid_reg;
    assign alloc_block = alloc_block_reg;
    assign status      = status_reg;
    assign out_free    = !out_valid_reg || out_ready;

    // usable bit count, clamped to the map size
    always_comb
    begin
        if (zc_reg > bba_pkg::ZC_W'(bba_pkg::MAP_BITS))
        begin
            limit = bba_pkg::LIM_W'(bba_pkg::MAP_BITS);
        end
        else
        begin
            limit = bba_pkg::LIM_W'(zc_reg);
        end
    end

    assign limit_m1  = limit - bba_pkg::LIM_W'(1);
    assign last_word = limit_m1[bba_pkg::IDX_W-1:bba_pkg::BIT_W];
    assign lim_words = limit >> bba_pkg::BIT_W;
    assign lim_rem   = limit[bba_pkg::BIT_W-1:0];

    // bits of the checked word that lie below the usable count
    always_comb
    begin
        if (bba_pkg::LIM_W'(chk_word_reg) < lim_words)
        begin
            elig_mask = '1;
        end
        else if (bba_pkg::LIM_W'(chk_word_reg) == lim_words)
        begin
            for (int i = 0; i < bba_pkg::WORD_BITS; i++)
            begin
                elig_mask[i] = (bba_pkg::BIT_W'(i) < lim_rem);
            end
        end
        else
        begin
            elig_mask = '0;
        end
    end

    // a never-written word reads as all free
    assign cur_word = rvld_reg ? rdata_reg : '0;
    assign cand     = ~cur_word & elig_mask;
    assign hit      = |cand;
    assign hit_pos  = lowest_set(cand);
    assign hit_idx  = {chk_word_reg, hit_pos};

    // free: index = block_number - first_data_block + 1, sign kept
    assign fidx = bba_pkg::FIDX_W'(block_number) - bba_pkg::FIDX_W'(fdb_reg)
                + bba_pkg::FIDX_W'(1);
    assign free_oor = fidx[bba_pkg::FIDX_W-1]
                   || (fidx[bba_pkg::FIDX_W-2:0] >= (bba_pkg::FIDX_W - 1)'(limit));

    always_comb
    begin
        state_next      = state_reg;
        rd_word_next    = rd_word_reg;
        chk_word_next   = chk_word_reg;
        chk_vld_next    = 1'b0;
        bit_sel_next    = bit_sel_reg;
        res_block_next  = res_block_reg;
        res_status_next = res_status_reg;
        mem_we          = 1'b0;
        mem_waddr       = rd_word_reg;
        mem_wdata       = cur_word;

        case (state_reg)
            bba_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    res_block_next  = '0;
                    res_status_next = bba_pkg::STAT_DONE;
                    if (func == bba_pkg::FUNC_ALLOC)
                    begin
                        rd_word_next = '0;
                        if (limit == '0)
                        begin
                            res_status_next = bba_pkg::STAT_FULL;
                            state_next      = bba_pkg::ST_FIN;
                        end
                        else
                        begin
                            state_next = bba_pkg::ST_SCAN;
                        end
                    end
                    else if (free_oor)
                    begin
                        res_status_next = bba_pkg::STAT_RANGE;
                        state_next      = bba_pkg::ST_FIN;
                    end
                    else
                    begin
                        rd_word_next = fidx[bba_pkg::IDX_W-1:bba_pkg::BIT_W];
                        bit_sel_next = fidx[bba_pkg::BIT_W-1:0];
                        state_next   = bba_pkg::ST_FREE_RD;
                    end
                end
            end

            bba_pkg::ST_SCAN:
            begin
                // read one word ahead of the check
                chk_vld_next  = 1'b1;
                chk_word_next = rd_word_reg;
                if (rd_word_reg != last_word)
                begin
                    rd_word_next = rd_word_reg + bba_pkg::ADDR_W'(1);
                end
                if (chk_vld_reg)
                begin
                    if (hit)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = chk_word_reg;
                        mem_wdata = cur_word | (bba_pkg::WORD_BITS'(1) << hit_pos);
                        res_block_next = bba_pkg::ALLOC_W'(fdb_reg)
                                       + bba_pkg::ALLOC_W'(hit_idx)
                                       - bba_pkg::ALLOC_W'(1);
                        chk_vld_next = 1'b0;
                        state_next   = bba_pkg::ST_FIN;
                    end
                    else if (chk_word_reg == last_word)
                    begin
                        res_status_next = bba_pkg::STAT_FULL;
                        chk_vld_next    = 1'b0;
                        state_next      = bba_pkg::ST_FIN;
                    end
                end
            end

            bba_pkg::ST_FREE_RD:
            begin
                state_next = bba_pkg::ST_FREE_WR;
            end

            bba_pkg::ST_FREE_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = rd_word_reg;
                mem_wdata  = cur_word & ~(bba_pkg::WORD_BITS'(1) << bit_sel_reg);
                state_next = bba_pkg::ST_FIN;
            end

            bba_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = bba_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = bba_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bba_pkg::ST_IDLE;
            fdb_reg       <= bba_pkg::FDB_W'(1);
            zc_reg        <= bba_pkg::ZC_W'(bba_pkg::MAP_BITS);
            word_vld_reg  <= '0;
            chk_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            chk_vld_reg <= chk_vld_next;
            if (cfg_we)
            begin
                if (cfg_index == bba_pkg::REG_FIRST_DATA_BLOCK)
                begin
                    fdb_reg <= cfg_data[bba_pkg::FDB_W-1:0];
                end
                else if (cfg_index == bba_pkg::REG_ZONE_COUNT)
                begin
                    zc_reg <= cfg_data[bba_pkg::ZC_W-1:0];
                end
            end
            if (mem_we)
            begin
                word_vld_reg[mem_waddr] <= 1'b1;
            end
            if (state_reg == bba_pkg::ST_FIN && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rd_word_reg    <= rd_word_next;
        chk_word_reg   <= chk_word_next;
        bit_sel_reg    <= bit_sel_next;
        res_block_reg  <= res_block_next;
        res_status_reg <= res_status_next;
        if (state_reg == bba_pkg::ST_FIN && out_free)
        begin
            alloc_block_reg <= res_block_reg;
            status_reg      <= res_status_reg;
        end
    end

    // map memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= map_mem[rd_word_reg];
        rvld_reg  <= word_vld_reg[rd_word_reg];
    end

`ifndef SYNTHESIS
    a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == bba_pkg::ST_SCAN || state_reg == bba_pkg::ST_FREE_WR))
        else $error("map write outside scan or free");

    a_vld_set: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> word_vld_reg[$past(mem_waddr)])
        else $error("written word not marked valid");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bba_pkg::ST_SCAN && chk_vld_reg) |-> (chk_word_reg <= last_word))
        else $error("scan checked a word past the usable count");

    a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bba_pkg::ST_FIN && out_free) |=>
            (out_valid_reg && state_reg == bba_pkg::ST_IDLE))
        else $error("finished item not presented");
`endif

endmodule

`default_nettype wire

/* bench/bba_result_check.sv */
// result checker: mirrors the allocator free map and compares every result item
module bba_result_check
    import bba_pkg::*;
(
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     cfg_we,
    input  wire [CFG_IDX_W-1:0]     cfg_index,
    input  wire [CFG_DATA_W-1:0]    cfg_data,
    input  wire                     in_valid,
    input  wire                     in_ready,
    input  wire                     func,
    input  wire [BLK_W-1:0]         block_number,
    input  wire                     out_valid,
    input  wire                     out_ready,
    input  wire [ALLOC_W-1:0]       alloc_block,
    input  wire [STATUS_W-1:0]      status,
    output int                      errors,
    output int                      pending
);

    typedef struct packed {
        logic [ALLOC_W-1:0]  alloc_block;
        logic [STATUS_W-1:0] status;
    } grant_t;

    logic [MAP_BITS-1:0] shadow_map;
    logic [FDB_W-1:0]    shadow_fdb;
    logic [ZC_W-1:0]     shadow_zones;
    grant_t              expected_grants[$];

    // first-fit search on allocate, index check and clear on free
    function automatic grant_t predict_request(input logic f, input logic [BLK_W-1:0] b);
        grant_t r;
        int     limit;
        int     i;
        int     idx;
        int     blk_out;
        bit     found;
        r = '0;
        found = 1'b0;
        limit = (int'(shadow_zones) > MAP_BITS) ? MAP_BITS : int'(shadow_zones);
        if (f == FUNC_ALLOC)
        begin
            for (i = 0; i < limit && !found; i++)
            begin
                if (!shadow_map[i])
                begin
                    shadow_map[i] = 1'b1;
                    // wraps to 17 bits when the first data block is zero
                    blk_out = int'(shadow_fdb) + i - 1;
                    r.alloc_block = blk_out[ALLOC_W-1:0];
                    found = 1'b1;
                end
            end
            if (!found)
                r.status = STAT_FULL;
        end
        else
        begin
            idx = int'(b) - int'(shadow_fdb) + 1;
            if (idx < 0 || idx >= limit)
                r.status = STAT_RANGE;
            else
                shadow_map[idx] = 1'b0;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        grant_t want;
        if (!rst_n)
        begin
            shadow_map = '0;
            shadow_fdb = 16'd1;
            shadow_zones = 13'd4096;
            expected_grants.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_FIRST_DATA_BLOCK)
                    shadow_fdb = cfg_data[FDB_W-1:0];
                else if (cfg_index == REG_ZONE_COUNT)
                    shadow_zones = cfg_data[ZC_W-1:0];
            end
            if (out_valid && out_ready)
            begin
                if (expected_grants.size() == 0)
                begin
                    $error("unexpected result item: alloc_block %0d status %0d",
                           alloc_block, status);
                    errors++;
                end
                else
                begin
                    want = expected_grants.pop_front();
                    if (alloc_block !== want.alloc_block)
                    begin
                        $error("alloc_block: expected %0d, got %0d",
                               want.alloc_block, alloc_block);
                        errors++;
                    end
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_grants.push_back(predict_request(func, block_number));
            pending = expected_grants.size();
        end
    end

endmodule

/* bench/tb.sv */
// testbench top: request stimulus, result sink and verdict for the bitmap allocator
module tb;
    import bba_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  func = FUNC_ALLOC;
    logic [BLK_W-1:0]      block_number = '0;
    logic                  out_ready = 1'b0;
    wire                   in_ready;
    wire                   out_valid;
    wire [ALLOC_W-1:0]     alloc_block;
    wire [STATUS_W-1:0]    status;

    int errors;
    int pending;
    int hold_left = 0;
    int requests_sent = 0;
    bit feed_steady = 1'b0;
    bit sink_steady = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    block_bitmap_allocator_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .block_number (block_number),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .alloc_block  (alloc_block),
        .status       (status)
    );

    bba_result_check grant_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .block_number (block_number),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .alloc_block  (alloc_block),
        .status       (status),
        .errors       (errors),
        .pending      (pending)
    );

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 93)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // result sink with random back-pressure
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else
        begin
            out_ready <= 1'b1;
            if (!sink_steady && $urandom_range(0, 2) == 0)
                hold_left = pick_gap();
        end
    end

    // called at a falling edge; returns at the falling edge after the item is taken
    task automatic send_request(input logic f, input logic [BLK_W-1:0] b);
        in_valid <= 1'b1;
        func <= f;
        block_number <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        requests_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_config(input logic [FDB_W-1:0] fdb,
                                input logic [CFG_DATA_W-1:0] zone_word);
        cfg_we <= 1'b1;
        cfg_index <= REG_FIRST_DATA_BLOCK;
        cfg_data <= fdb;
        @(negedge clk);
        cfg_index <= REG_ZONE_COUNT;
        cfg_data <= zone_word;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input logic [FDB_W-1:0] fdb, input int zones, input int n,
                             input int alloc_pct);
        logic [CFG_DATA_W-1:0] zone_word;
        logic                  f;
        logic [BLK_W-1:0]      b;
        int                    lim;
        int                    span;
        int                    k;
        int                    gap;
        int                    pick;
        zone_word = '0;
        zone_word[ZC_W-1:0] = zones[ZC_W-1:0];
        // upper data bits are dropped by the zone count register
        if ($urandom_range(0, 3) == 0)
            zone_word[CFG_DATA_W-1:ZC_W] = (CFG_DATA_W - ZC_W)'($urandom_range(0, 7));
        lim = (zones > MAP_BITS) ? MAP_BITS : zones;
        span = (lim > 256) ? 320 : lim + 1;
        write_config(fdb, zone_word);
        feed_steady = ($urandom_range(0, 3) == 0);
        sink_steady = ($urandom_range(0, 3) == 0);
        for (k = 0; k < n; k++)
        begin
            f = ($urandom_range(0, 99) < alloc_pct) ? FUNC_ALLOC : FUNC_FREE;
            // frees mostly aim just around the usable window
            pick = int'(fdb) - 1 + $urandom_range(0, span);
            if (f == FUNC_FREE && $urandom_range(0, 99) < 85)
                b = pick[BLK_W-1:0];
            else
                b = BLK_W'($urandom_range(0, 65535));
            gap = (feed_steady || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            send_request(f, b);
        end
        drain();
    endtask

    initial
    begin : stimulus
        logic [FDB_W-1:0] fdb_pick;
        int               zone_pick;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset configuration: first data block 1, full map
        send_request(FUNC_ALLOC, 16'd0);
        send_request(FUNC_ALLOC, 16'hFFFF);
        send_request(FUNC_FREE, 16'd0);
        send_request(FUNC_FREE, 16'd0);       // already free
        send_request(FUNC_FREE, 16'hFFFF);    // far past the map
        send_request(FUNC_ALLOC, 16'd0);
        send_request(FUNC_FREE, 16'd4095);    // last map bit
        send_request(FUNC_FREE, 16'd4096);    // one past the last bit
        drain();

        // two-block window: fill it, then miss it on both sides
        write_config(16'd100, 16'd2);
        send_request(FUNC_FREE, 16'd100);
        send_request(FUNC_ALLOC, 16'd0);
        send_request(FUNC_ALLOC, 16'd0);
        send_request(FUNC_FREE, 16'd98);
        send_request(FUNC_FREE, 16'd101);
        send_request(FUNC_FREE, 16'd99);
        drain();

        // empty window
        write_config(16'd100, 16'd0);
        send_request(FUNC_ALLOC, 16'd0);
        send_request(FUNC_FREE, 16'd99);
        drain();

        // first data block zero: index zero wraps to the top of the result range
        write_config(16'd0, 16'd3);
        send_request(FUNC_ALLOC, 16'd0);
        send_request(FUNC_ALLOC, 16'd0);
        send_request(FUNC_ALLOC, 16'd0);
        send_request(FUNC_FREE, 16'hFFFF);
        send_request(FUNC_FREE, 16'd0);
        send_request(FUNC_ALLOC, 16'd0);
        drain();

        // highest first data block, zone count clamped to the map size
        write_config(16'hFFFF, 16'd8191);
        send_request(FUNC_ALLOC, 16'd0);
        send_request(FUNC_FREE, 16'd65533);
        send_request(FUNC_FREE, 16'd0);
        send_request(FUNC_FREE, 16'hFFFF);
        drain();

        // mostly allocates over the whole map so the scan crosses several words
        run_phase(16'd1, MAP_BITS, 300, 92);

        while (requests_sent < 1100)
        begin
            case ($urandom_range(0, 5))
                0:       fdb_pick = 16'd0;
                1:       fdb_pick = 16'd1;
                2:       fdb_pick = 16'hFFFF;
                3:       fdb_pick = FDB_W'($urandom_range(1, 200));
                default: fdb_pick = FDB_W'($urandom_range(1, 65535));
            endcase
            case ($urandom_range(0, 7))
                0:       zone_pick = 0;
                1:       zone_pick = 1;
                2:       zone_pick = WORD_BITS;
                3:       zone_pick = WORD_BITS + 1;
                4:       zone_pick = MAP_BITS;
                5:       zone_pick = $urandom_range(MAP_BITS + 1, 8191);
                default: zone_pick = $urandom_range(2, 200);
            endcase
            run_phase(fdb_pick, zone_pick, $urandom_range(20, 100), $urandom_range(35, 85));
        end

        // let any stray result item show up
        repeat (70) @(negedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : watchdog
        #8000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

/* sim.f */
rtl/bba_pkg.sv
rtl/block_bitmap_allocator_core.sv
bench/bba_result_check.sv
bench/tb.sv
